// ----- src/bir_pkg.sv -----
// Shared constants and types for the bilinear image resampler.
`timescale 1ns / 1ps

package bir_pkg;

    localparam int MAX_WIDTH    = 256;
    localparam int MAX_HEIGHT   = 256;
    localparam int MAX_CHANNELS = 4;
    localparam int FRAC_BITS    = 16;

    localparam int COORD_W  = 8;
    localparam int CHAN_W   = 8;
    localparam int PIX_W    = MAX_CHANNELS * CHAN_W;
    localparam int SCALE_W  = 24;
    localparam int DIM_W    = 9;
    localparam int CNT_W    = 3;
    localparam int CFG_W    = 24;
    localparam int CFG_IDX_W = 3;
    localparam int PROD_W   = COORD_W + SCALE_W;
    localparam int WGT_W    = 2 * (FRAC_BITS + 1);
    localparam int MUL_W    = CHAN_W + WGT_W;
    localparam int SUM_W    = MUL_W + 2;
    localparam int BANK_AW  = 2 * (COORD_W - 1);
    localparam int BANK_DEPTH = (MAX_WIDTH * MAX_HEIGHT) / 4;

    localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_X    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_Y    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CHAN_COUNT = 3'd4;

    localparam logic CMD_LOAD     = 1'b0;
    localparam logic CMD_RESAMPLE = 1'b1;

    typedef logic [CHAN_W-1:0] chan_t;
    typedef chan_t [MAX_CHANNELS-1:0] pixel_t;

endpackage

// ----- src/bilinear_image_resample_unit.sv -----
// Top level of the bilinear image resampler: load, map, fetch, blend, output.
// A resample transaction passes each stage register and the output register before m_tvalid.
// Throughput: one transaction per cycle; each of the four parity banks takes one read.
// An untaken result in the output register stalls every stage until m_tready.
// Load transactions write the source image and produce no output transaction.
// Reset (rst_n, async low) clears pipeline valid bits and sets config registers to defaults;
// the source image is undefined until loaded.
`timescale 1ns / 1ps

module bilinear_image_resample_unit (
    input  logic        clk,
    input  logic        rst_n,
    // slave stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,  // col[7:0], row[15:8], in_ch0..in_ch3[47:16]
    input  logic        s_tuser,  // cmd
    // master stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,  // out_ch0[7:0], out_ch1, out_ch2, out_ch3[31:24]
    // config write port
    input  logic        cfg_we,
    input  logic [2:0]  cfg_addr,
    input  logic [23:0] cfg_data
);

    localparam int NC = bir_pkg::MAX_CHANNELS;
    localparam int FB = bir_pkg::FRAC_BITS;
    localparam int CW = bir_pkg::COORD_W;

    // ---------------- configuration ----------------
    logic [bir_pkg::DIM_W-1:0]   src_width_reg, src_height_reg;
    logic [bir_pkg::SCALE_W-1:0] scale_x_reg, scale_y_reg;
    logic [bir_pkg::CNT_W-1:0]   chan_count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_width_reg  <= 9'd256;
            src_height_reg <= 9'd256;
            scale_x_reg    <= 24'd65536;
            scale_y_reg    <= 24'd65536;
            chan_count_reg <= 3'd3;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                bir_pkg::REG_SRC_WIDTH:  src_width_reg  <= cfg_data[8:0];
                bir_pkg::REG_SRC_HEIGHT: src_height_reg <= cfg_data[8:0];
                bir_pkg::REG_SCALE_X:    scale_x_reg    <= cfg_data;
                bir_pkg::REG_SCALE_Y:    scale_y_reg    <= cfg_data;
                bir_pkg::REG_CHAN_COUNT: chan_count_reg <= cfg_data[2:0];
                default: ;
            endcase
        end
    end

    // Whole pipeline advances unless the output register holds an untaken result.
    logic adv;
    assign adv      = !m_tvalid || m_tready;
    assign s_tready = adv;

    // ---------------- stage 1: input register ----------------
    logic            s1_v_reg, s1_cmd_reg;
    logic [CW-1:0]   s1_col_reg, s1_row_reg;
    bir_pkg::pixel_t s1_pix_reg;

    // ---------------- stage 2: scaled coordinates ----------------
    logic                       s2_v_reg, s2_cmd_reg;
    logic [bir_pkg::PROD_W-1:0] s2_px_reg, s2_py_reg;
    logic [CW-1:0]              s2_col_reg, s2_row_reg;
    bir_pkg::pixel_t            s2_pix_reg;

    // ---------------- stage 3: RAM data out ----------------
    logic          s3_v_reg;
    logic          s3_x0b_reg, s3_x1b_reg, s3_y0b_reg, s3_y1b_reg;
    logic [FB-1:0] s3_fx_reg, s3_fy_reg;

    // ---------------- stage 4: weights and neighbors ----------------
    logic                      s4_v_reg;
    logic [bir_pkg::WGT_W-1:0] s4_w_reg [4];
    bir_pkg::pixel_t           s4_p_reg [4];

    // ---------------- stage 5: per-channel products ----------------
    logic                      s5_v_reg;
    logic [bir_pkg::MUL_W-1:0] s5_m_reg [NC][4];

    // ---------------- output register ----------------
    logic            out_v_reg;
    bir_pkg::pixel_t out_pix_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg  <= 1'b0;
            s2_v_reg  <= 1'b0;
            s3_v_reg  <= 1'b0;
            s4_v_reg  <= 1'b0;
            s5_v_reg  <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_v_reg  <= s_tvalid;
            s2_v_reg  <= s1_v_reg;
            // loads end at the RAM write; only resamples go on
            s3_v_reg  <= s2_v_reg && (s2_cmd_reg == bir_pkg::CMD_RESAMPLE);
            s4_v_reg  <= s3_v_reg;
            s5_v_reg  <= s4_v_reg;
            out_v_reg <= s5_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_cmd_reg <= s_tuser;
            s1_col_reg <= s_tdata[7:0];
            s1_row_reg <= s_tdata[15:8];
            s1_pix_reg <= s_tdata[47:16];

            s2_cmd_reg <= s1_cmd_reg;
            s2_col_reg <= s1_col_reg;
            s2_row_reg <= s1_row_reg;
            s2_pix_reg <= s1_pix_reg;
            s2_px_reg  <= bir_pkg::PROD_W'(s1_col_reg) * bir_pkg::PROD_W'(scale_x_reg);
            s2_py_reg  <= bir_pkg::PROD_W'(s1_row_reg) * bir_pkg::PROD_W'(scale_y_reg);
        end
    end

    // ---------------- stage 2 logic: clamp and bank addressing ----------------
    logic [CW-1:0] last_x, last_y, x0, x1, y0, y1;
    logic [bir_pkg::PROD_W-FB-1:0] base_x, base_y;

    always_comb
    begin
        // saturated extent minus one
        if (src_width_reg == '0 || src_width_reg[8])
        begin
            last_x = (src_width_reg == '0) ? '0 : '1;
        end
        else
        begin
            last_x = src_width_reg[7:0] - 8'd1;
        end
        if (src_height_reg == '0 || src_height_reg[8])
        begin
            last_y = (src_height_reg == '0) ? '0 : '1;
        end
        else
        begin
            last_y = src_height_reg[7:0] - 8'd1;
        end
        base_x = s2_px_reg[bir_pkg::PROD_W-1:FB];
        base_y = s2_py_reg[bir_pkg::PROD_W-1:FB];
        if (base_x >= {8'd0, last_x})
        begin
            x0 = last_x;
            x1 = last_x;
        end
        else
        begin
            x0 = base_x[CW-1:0];
            x1 = base_x[CW-1:0] + 8'd1;
        end
        if (base_y >= {8'd0, last_y})
        begin
            y0 = last_y;
            y1 = last_y;
        end
        else
        begin
            y0 = base_y[CW-1:0];
            y1 = base_y[CW-1:0] + 8'd1;
        end
    end

    // Banks by {row parity, column parity}; each bank reads the neighbor of its parity.
    logic                         ram_we  [4];
    logic                         ram_re;
    logic [bir_pkg::BANK_AW-1:0]  ram_raddr [4];
    logic [bir_pkg::BANK_AW-1:0]  ram_waddr;
    logic [bir_pkg::PIX_W-1:0]    ram_rdata [4];

    assign ram_re    = adv && s2_v_reg && (s2_cmd_reg == bir_pkg::CMD_RESAMPLE);
    assign ram_waddr = {s2_row_reg[CW-1:1], s2_col_reg[CW-1:1]};

    for (genvar b = 0; b < 4; b++)
    begin : g_bank
        localparam logic [1:0] BANK_ID = 2'(b);
        logic [CW-1:0] ysel, xsel;
        assign ysel = (y0[0] == BANK_ID[1]) ? y0 : y1;
        assign xsel = (x0[0] == BANK_ID[0]) ? x0 : x1;
        assign ram_raddr[b] = {ysel[CW-1:1], xsel[CW-1:1]};
        assign ram_we[b] = adv && s2_v_reg && (s2_cmd_reg == bir_pkg::CMD_LOAD)
                           && ({s2_row_reg[0], s2_col_reg[0]} == BANK_ID);

        bir_ram #(
            .WIDTH(bir_pkg::PIX_W),
            .DEPTH(bir_pkg::BANK_DEPTH)
        ) u_bank (
            .clk   (clk),
            .we    (ram_we[b]),
            .waddr (ram_waddr),
            .wdata (s2_pix_reg),
            .re    (ram_re),
            .raddr (ram_raddr[b]),
            .rdata (ram_rdata[b])
        );
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s3_x0b_reg <= x0[0];
            s3_x1b_reg <= x1[0];
            s3_y0b_reg <= y0[0];
            s3_y1b_reg <= y1[0];
            s3_fx_reg  <= s2_px_reg[FB-1:0];
            s3_fy_reg  <= s2_py_reg[FB-1:0];
        end
    end

    // ---------------- stage 3 logic: weights, neighbor routing ----------------
    logic [FB:0] fx_e, fy_e, ifx, ify;
    assign fx_e = {1'b0, s3_fx_reg};
    assign fy_e = {1'b0, s3_fy_reg};
    assign ifx  = (17'd1 << FB) - fx_e;
    assign ify  = (17'd1 << FB) - fy_e;

    // neighbor order: 00 = (y0,x0), 10 = (y1,x0), 01 = (y0,x1), 11 = (y1,x1)
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s4_w_reg[0] <= bir_pkg::WGT_W'(ify) * bir_pkg::WGT_W'(ifx);
            s4_w_reg[1] <= bir_pkg::WGT_W'(fy_e) * bir_pkg::WGT_W'(ifx);
            s4_w_reg[2] <= bir_pkg::WGT_W'(ify) * bir_pkg::WGT_W'(fx_e);
            s4_w_reg[3] <= bir_pkg::WGT_W'(fy_e) * bir_pkg::WGT_W'(fx_e);
            s4_p_reg[0] <= ram_rdata[{s3_y0b_reg, s3_x0b_reg}];
            s4_p_reg[1] <= ram_rdata[{s3_y1b_reg, s3_x0b_reg}];
            s4_p_reg[2] <= ram_rdata[{s3_y0b_reg, s3_x1b_reg}];
            s4_p_reg[3] <= ram_rdata[{s3_y1b_reg, s3_x1b_reg}];
        end
    end

    // ---------------- stage 4 logic: channel times weight ----------------
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int c = 0; c < NC; c++)
            begin
                for (int n = 0; n < 4; n++)
                begin
                    s5_m_reg[c][n] <= bir_pkg::MUL_W'(s4_p_reg[n][c])
                                      * bir_pkg::MUL_W'(s4_w_reg[n]);
                end
            end
        end
    end

    // ---------------- stage 5 logic: sum, truncate, mask channels ----------------
    bir_pkg::pixel_t blend;
    logic [bir_pkg::SUM_W-1:0] acc [NC];

    always_comb
    begin
        for (int c = 0; c < NC; c++)
        begin
            acc[c] = bir_pkg::SUM_W'(s5_m_reg[c][0]) + bir_pkg::SUM_W'(s5_m_reg[c][1])
                   + bir_pkg::SUM_W'(s5_m_reg[c][2]) + bir_pkg::SUM_W'(s5_m_reg[c][3]);
            // count above the channel limit saturates, so c < count alone decides
            if (c < int'(chan_count_reg))
            begin
                blend[c] = acc[c][2*FB +: bir_pkg::CHAN_W];
            end
            else
            begin
                blend[c] = '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_pix_reg <= blend;
        end
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata  = out_pix_reg;

`ifndef SYNTH
    // load transactions never reach the blend stages
    a_no_load_in_blend: assert property (@(posedge clk) disable iff (!rst_n)
        (s2_v_reg && s2_cmd_reg == bir_pkg::CMD_LOAD && adv) |=> !s3_v_reg)
        else $error("load transaction leaked past RAM stage");

    // a stall freezes every stage valid bit
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> ($stable(s1_v_reg) && $stable(s2_v_reg) && $stable(s3_v_reg)
                  && $stable(s4_v_reg) && $stable(s5_v_reg)))
        else $error("pipeline moved during stall");

    // at most one bank writes, and RAM writes and reads never happen in the same cycle
    a_we_re_excl: assert property (@(posedge clk) disable iff (!rst_n)
        $countones({ram_we[0], ram_we[1], ram_we[2], ram_we[3]}) <= 1
        && !(ram_re && (ram_we[0] || ram_we[1] || ram_we[2] || ram_we[3])))
        else $error("RAM write collides with read");
`endif

endmodule

// ----- src/bir_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module bir_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
